// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that is also checked across reset
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/rsmh_pkg.sv -----
// Types, constants and codes shared by the RAID5 sector map and health block
`default_nettype none

package rsmh_pkg;

  localparam int MAX_DISKS = 16;
  localparam int MIN_DISKS = 3;

  localparam int SEC_W  = 25;
  localparam int ROW_W  = 21;
  localparam int DEV_W  = 4;
  localparam int CNT_W  = 5;
  localparam int DVD_W  = SEC_W + 1;
  localparam int DVS_W  = 8;
  localparam int STEP_W = $clog2(DVD_W);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ERROR = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ARR_STOPPED  = 2'd0,
    ARR_OK       = 2'd1,
    ARR_DEGRADED = 2'd2,
    ARR_FAILED   = 2'd3
  } health_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_ROW,
    ST_PAR,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    op_t              op;
    logic [SEC_W-1:0] sector;
    logic [DEV_W-1:0] edev;
    logic             edev_in_array;
    health_t          lstat;
    logic [DEV_W-1:0] lfail;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             accepted;
    logic [DEV_W-1:0] data_device;
    logic [ROW_W-1:0] row;
    logic [DEV_W-1:0] parity_device;
    logic             rebuild_data;
    logic             rebuild_parity;
    logic             write_data_enable;
    logic             write_parity_enable;
    health_t          health;
    logic [DEV_W-1:0] bad_device;
  } result_t;

endpackage

`default_nettype wire

// ----- design/rsmh_front.sv -----
// Front end: input acceptance, item classification, disk count register and item queue
`default_nettype none

module rsmh_front import rsmh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_operation,
  input  logic [SEC_W-1:0] in_logical_sector,
  input  logic [DEV_W-1:0] in_error_device,
  input  logic [1:0]       in_load_status,
  input  logic [DEV_W-1:0] in_load_bad_device,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_num_devices,
  output logic             q_valid,
  output item_t            q_item,
  input  logic             q_pop,
  output logic [CNT_W-1:0] n_eff,
  output logic [DVS_W-1:0] n_pair
);

  logic [CNT_W-1:0]  n_eff_r;
  logic [CNT_W-1:0]  n_clamp;
  logic [DVS_W-1:0]  n_pair_r;
  logic [DVS_W-1:0]  n_pair_nxt;
  item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              push_ok;
  logic              pop_ok;
  item_t             item_in;

  assign cfg_ready = 1'b1;

  // out-of-range disk counts act as the nearest bound
  always_comb begin
    n_clamp = cfg_num_devices;
    if (cfg_num_devices < CNT_W'(MIN_DISKS)) begin
      n_clamp = CNT_W'(MIN_DISKS);
    end else if (cfg_num_devices > CNT_W'(MAX_DISKS)) begin
      n_clamp = CNT_W'(MAX_DISKS);
    end
    n_pair_nxt = DVS_W'(n_clamp) * (DVS_W'(n_clamp) - DVS_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r  <= CNT_W'(MIN_DISKS);
      n_pair_r <= DVS_W'(MIN_DISKS * (MIN_DISKS - 1));
    end else if (cfg_valid && cfg_ready) begin
      n_eff_r  <= n_clamp;
      n_pair_r <= n_pair_nxt;
    end
  end

  assign n_eff  = n_eff_r;
  assign n_pair = n_pair_r;

  always_comb begin
    item_in.op            = op_t'(in_operation);
    item_in.sector        = in_logical_sector;
    item_in.edev          = in_error_device;
    item_in.edev_in_array = {1'b0, in_error_device} < n_eff_r;
    item_in.lstat         = health_t'(in_load_status);
    item_in.lfail         = (health_t'(in_load_status) == ARR_DEGRADED) ?
                            in_load_bad_device : '0;
  end

  assign in_full = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;
  assign cnt_nxt = cnt_r + QCNT_W'(push_ok) - QCNT_W'(pop_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ----- design/rsmh_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module rsmh_div import rsmh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  quot_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              ge;
  logic [DVS_W-1:0]  rem_nxt;

  // partial remainder stays below the divisor, so the shifted value fits DVS_W+1 bits
  always_comb begin
    rem_sh  = {rem_r, quot_r[DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
    rem_nxt = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[DVD_W-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// ----- design/rsmh_back.sv -----
// Back end: mapping sequencer over two dividers, health state and result register
`default_nettype none

module rsmh_back import rsmh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  input  logic [CNT_W-1:0] n_eff,
  input  logic [DVS_W-1:0] n_pair,
  output logic             out_valid,
  output result_t          out_res,
  input  logic             out_pop
);

  seq_state_t       state_r;
  seq_state_t       state_nxt;
  health_t          health_r;
  health_t          health_nxt;
  logic [DEV_W-1:0] fail_r;
  logic [DEV_W-1:0] fail_nxt;
  item_t            cur_r;
  logic [DEV_W-1:0] ddev_r;
  logic [ROW_W-1:0] row_r;
  result_t          res_r;
  result_t          out_r;
  logic             out_valid_r;

  div_req_t         a_req;
  div_rsp_t         a_rsp;
  div_req_t         b_req;
  div_rsp_t         b_rsp;

  logic             is_plan;
  logic             running;
  logic             degr;
  logic             plan_go;
  logic             idle_take;
  logic             load_out;
  logic             res_from_idle;
  logic             res_from_plan;
  logic [DVD_W-1:0] t_sum;
  logic [DEV_W-1:0] pdev;
  result_t          idle_res;
  result_t          plan_res;

  rsmh_div u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (a_req),
    .rsp   (a_rsp)
  );

  rsmh_div u_div_b (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (b_req),
    .rsp   (b_rsp)
  );

  assign is_plan = (q_item.op == OP_READ) || (q_item.op == OP_WRITE);
  assign running = (health_r == ARR_OK) || (health_r == ARR_DEGRADED);
  assign degr    = (health_r == ARR_DEGRADED);
  assign plan_go = q_valid && is_plan && running;

  // t = s + s/N + 1 + s/(N(N-1)); both quotients finish on the same cycle
  assign t_sum = DVD_W'(cur_r.sector) + a_rsp.quot + b_rsp.quot + DVD_W'(1);
  assign pdev  = a_rsp.rem[DEV_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = plan_go ? ST_SPLIT : ST_EMIT;
        end
      end
      ST_SPLIT: begin
        if (a_rsp.done) begin
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        if (a_rsp.done) begin
          state_nxt = ST_PAR;
        end
      end
      ST_PAR: begin
        if (a_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_pop) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop          = 1'b0;
    idle_take      = 1'b0;
    load_out       = 1'b0;
    res_from_idle  = 1'b0;
    res_from_plan  = 1'b0;
    a_req.start    = 1'b0;
    a_req.dividend = '0;
    a_req.divisor  = DVS_W'(n_eff);
    b_req.start    = 1'b0;
    b_req.dividend = DVD_W'(q_item.sector);
    b_req.divisor  = n_pair;
    case (state_r)
      ST_IDLE: begin
        q_pop          = q_valid;
        idle_take      = q_valid;
        res_from_idle  = q_valid && !plan_go;
        a_req.start    = plan_go;
        b_req.start    = plan_go;
        a_req.dividend = DVD_W'(q_item.sector);
      end
      ST_SPLIT: begin
        a_req.start    = a_rsp.done;
        a_req.dividend = t_sum;
      end
      ST_ROW: begin
        a_req.start    = a_rsp.done;
        a_req.dividend = a_rsp.quot;
      end
      ST_PAR: begin
        res_from_plan = a_rsp.done;
      end
      ST_EMIT: begin
        load_out = !out_valid_r || out_pop;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // health update and result for items that need no mapping
  always_comb begin
    health_nxt = health_r;
    fail_nxt   = fail_r;
    idle_res   = '0;
    case (q_item.op)
      OP_ERROR: begin
        if (running && q_item.edev_in_array) begin
          idle_res.accepted = 1'b1;
          if (health_r == ARR_OK) begin
            health_nxt = ARR_DEGRADED;
            fail_nxt   = q_item.edev;
          end else if (fail_r != q_item.edev) begin
            health_nxt = ARR_FAILED;
            fail_nxt   = '0;
          end
        end
      end
      OP_LOAD: begin
        idle_res.accepted = 1'b1;
        health_nxt        = q_item.lstat;
        fail_nxt          = q_item.lfail;
      end
      default: begin
        idle_res.accepted = 1'b0;
      end
    endcase
    idle_res.health     = health_nxt;
    idle_res.bad_device = (health_nxt == ARR_DEGRADED) ? fail_nxt : '0;
  end

  always_comb begin
    plan_res                     = '0;
    plan_res.accepted            = 1'b1;
    plan_res.data_device         = ddev_r;
    plan_res.row                 = row_r;
    plan_res.parity_device       = pdev;
    plan_res.rebuild_data        = degr && (fail_r == ddev_r);
    if (cur_r.op == OP_WRITE) begin
      plan_res.rebuild_parity      = degr && (fail_r == pdev);
      plan_res.write_data_enable   = !degr || (fail_r != ddev_r);
      plan_res.write_parity_enable = !degr || (fail_r != pdev);
    end
    plan_res.health              = health_r;
    plan_res.bad_device          = degr ? fail_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      health_r    <= ARR_STOPPED;
      fail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (idle_take) begin
        health_r <= health_nxt;
        fail_r   <= fail_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (idle_take) begin
      cur_r <= q_item;
    end
    if ((state_r == ST_ROW) && a_rsp.done) begin
      ddev_r <= a_rsp.rem[DEV_W-1:0];
      row_r  <= a_rsp.quot[ROW_W-1:0];
    end
    if (res_from_idle) begin
      res_r <= idle_res;
    end else if (res_from_plan) begin
      res_r <= plan_res;
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

// ----- design/raid5_sector_map_health.sv -----
// RAID5 sector mapping and array health: top level
// Usage:
//   Requests enter through a queue-style port: an item is taken at a clock edge
//   with in_push high and in_full low. Results leave the same way: the oldest
//   result sits on the out_ ports while out_empty is low and is taken at an
//   edge with out_pop high. Every item gives exactly one result, in order.
//   The disk count is written through cfg_valid/cfg_ready/cfg_num_devices
//   (always ready), by the user only while no item is in flight (unchecked).
// Mapping and item order:
//   A read or write plan on a running array needs three passes through the
//   26-step radix-2 divider (s/N alongside s/(N(N-1)), then t/N, then row mod N):
//   its result is registered after the third pass. Error reports, loads and
//   rejected plans skip the divider. The sequencer takes no new item until
//   the result of the last one has moved to the output register.
// Reset and stalls:
//   rst_n (synchronous, active low) empties both queues, sets the array to
//   stopped and the disk count to 3. A receiver that holds off pop keeps the
//   result steady; the two-entry input queue keeps taking items until it fills.
`default_nettype none

module raid5_sector_map_health import rsmh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_operation,
  input  logic [SEC_W-1:0] in_logical_sector,
  input  logic [DEV_W-1:0] in_error_device,
  input  logic [1:0]       in_load_status,
  input  logic [DEV_W-1:0] in_load_bad_device,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_num_devices,
  output logic             out_empty,
  input  logic             out_pop,
  output logic             out_accepted,
  output logic [DEV_W-1:0] out_data_device,
  output logic [ROW_W-1:0] out_row,
  output logic [DEV_W-1:0] out_parity_device,
  output logic             out_rebuild_data,
  output logic             out_rebuild_parity,
  output logic             out_write_data_enable,
  output logic             out_write_parity_enable,
  output logic [1:0]       out_health,
  output logic [DEV_W-1:0] out_bad_device
);

  logic             q_valid;
  item_t            q_item;
  logic             q_pop;
  logic [CNT_W-1:0] n_eff;
  logic [DVS_W-1:0] n_pair;
  logic             res_valid;
  result_t          res;

  rsmh_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_operation       (in_operation),
    .in_logical_sector  (in_logical_sector),
    .in_error_device    (in_error_device),
    .in_load_status     (in_load_status),
    .in_load_bad_device (in_load_bad_device),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_num_devices    (cfg_num_devices),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .n_eff              (n_eff),
    .n_pair             (n_pair)
  );

  rsmh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .n_eff     (n_eff),
    .n_pair    (n_pair),
    .out_valid (res_valid),
    .out_res   (res),
    .out_pop   (out_pop)
  );

  assign out_empty               = !res_valid;
  assign out_accepted            = res.accepted;
  assign out_data_device         = res.data_device;
  assign out_row                 = res.row;
  assign out_parity_device       = res.parity_device;
  assign out_rebuild_data        = res.rebuild_data;
  assign out_rebuild_parity      = res.rebuild_parity;
  assign out_write_data_enable   = res.write_data_enable;
  assign out_write_parity_enable = res.write_parity_enable;
  assign out_health              = res.health;
  assign out_bad_device          = res.bad_device;

endmodule

`default_nettype wire

// ----- design/rsmh_chk.sv -----
// Port-level checker for the RAID5 sector map block, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module rsmh_chk import rsmh_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_push,
  input logic             in_full,
  input logic [1:0]       in_operation,
  input logic [SEC_W-1:0] in_logical_sector,
  input logic [DEV_W-1:0] in_error_device,
  input logic [1:0]       in_load_status,
  input logic [DEV_W-1:0] in_load_bad_device,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CNT_W-1:0] cfg_num_devices,
  input logic             out_empty,
  input logic             out_pop,
  input logic             out_accepted,
  input logic [DEV_W-1:0] out_data_device,
  input logic [ROW_W-1:0] out_row,
  input logic [DEV_W-1:0] out_parity_device,
  input logic             out_rebuild_data,
  input logic             out_rebuild_parity,
  input logic             out_write_data_enable,
  input logic             out_write_parity_enable,
  input logic [1:0]       out_health,
  input logic [DEV_W-1:0] out_bad_device
);

  // the output queue comes out of reset empty and the input queue not full
  `ASSERT_NORST(a_reset_empty, clk, !rst_n |=> (out_empty && !in_full), "queues not empty after reset")

  // a refused transaction carries no mapping
  `ASSERT_CLK(a_reject_clean, clk, rst_n, (!out_empty && !out_accepted) |-> (out_row == '0 && out_data_device == '0 && out_parity_device == '0 && !out_rebuild_data && !out_rebuild_parity && !out_write_data_enable && !out_write_parity_enable), "rejected result carries plan fields")

  `ASSERT_CLK(a_bad_dev_degraded, clk, rst_n, (!out_empty && out_health != ARR_DEGRADED) |-> (out_bad_device == '0 && !out_rebuild_data && !out_rebuild_parity), "failed disk shown outside degraded state")

  // a sector that must be rebuilt is never written directly
  `ASSERT_CLK(a_rebuild_vs_write, clk, rst_n, !out_empty |-> (!(out_rebuild_data && out_write_data_enable) && !(out_rebuild_parity && out_write_parity_enable)), "rebuild and direct write on the same disk")

  `ASSERT_CLK(a_stall_hold, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_row) && $stable(out_health) && $stable(out_accepted)), "result changed while stalled")

endmodule

bind raid5_sector_map_health rsmh_chk u_rsmh_chk (.*);

`default_nettype wire
